### rtl/bir_pkg.sv
package bir_pkg;

  localparam int unsigned MaxSrcRows = 256;
  localparam int unsigned MaxSrcCols = 256;

  localparam int unsigned RowW   = $clog2(MaxSrcRows);
  localparam int unsigned ColW   = $clog2(MaxSrcCols);
  localparam int unsigned BankRw = RowW - 1;
  localparam int unsigned BankCw = ColW - 1;
  localparam int unsigned BankAw = BankRw + BankCw;
  localparam int unsigned BankDepth = 2 ** BankAw;

  localparam int unsigned DimW  = 9;
  localparam int unsigned IdxW  = 10;
  localparam int unsigned StepW = 22;
  localparam int unsigned ProdW = StepW + IdxW + 1;
  localparam int unsigned WgtW  = 11;
  localparam int unsigned PixW  = 8;
  localparam int unsigned WordW = 3 * PixW;

  localparam logic [WgtW-1:0] WeightOne = WgtW'(1024);

  localparam logic OpLoad   = 1'b0;
  localparam logic OpInterp = 1'b1;

  typedef enum logic [1:0] {
    CFG_STEP       = 2'd0,
    CFG_SRC_ROWS   = 2'd1,
    CFG_SRC_COLS   = 2'd2,
    CFG_COLOR_MODE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic            operation;
    logic [IdxW-1:0] pos_row;
    logic [IdxW-1:0] pos_col;
    logic [PixW-1:0] pix_ch0;
    logic [PixW-1:0] pix_ch1;
    logic [PixW-1:0] pix_ch2;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] res_ch0;
    logic [PixW-1:0] res_ch1;
    logic [PixW-1:0] res_ch2;
  } out_item_t;

endpackage

### rtl/bilinear_image_resampler_top.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_stall_o   bir_pkg::in_item_t
// out      output     out_valid_o/out_stall_i bir_pkg::out_item_t
// cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// One item per cycle while the output register is not stalled; an interpolate
// result passes through stages 1 to 4 into the output register. The frame store
// is four banks by row and column parity, so the four neighbors come out of a single read.
// Reset clears the pipeline valids and the config registers, not the frame store.
// A stalled, full output register freezes the whole pipeline.
module bilinear_image_resampler_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bir_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bir_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [21:0]         cfg_data_i
);
  import bir_pkg::*;

  typedef struct packed {
    logic [RowW-1:0] lo;
    logic [WgtW-1:0] w1;
  } axis_t;

  function automatic axis_t pick_axis(input logic [ProdW-1:0] prod,
                                      input logic [DimW-1:0] n);
    logic [ProdW-1:0] c;
    logic [DimW-1:0]  top;
    logic [17:0]      rnd;
    axis_t            r;
    c   = (prod > ProdW'(65536)) ? prod - ProdW'(65536) : '0;
    top = n - DimW'(2);
    rnd = {1'b0, c[16:0]} + 18'd64;
    if (c[ProdW-1:17] > (ProdW-17)'(top)) begin
      r.lo = top[RowW-1:0];
      r.w1 = WeightOne;
    end else begin
      r.lo = c[17+RowW-1:17];
      r.w1 = rnd[17:7];
    end
    return r;
  endfunction

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] mx);
    if (v < DimW'(2)) return DimW'(2);
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic logic [PixW-1:0] mix(input logic [PixW-1:0] p0,
                                          input logic [PixW-1:0] p1,
                                          input logic [WgtW-1:0] w0,
                                          input logic [WgtW-1:0] w1);
    logic [PixW+WgtW-1:0] s;
    s = (PixW+WgtW)'(p0) * (PixW+WgtW)'(w0) + (PixW+WgtW)'(p1) * (PixW+WgtW)'(w1);
    return s[PixW+9:10];
  endfunction

  // configuration
  logic [StepW-1:0] step_q;
  logic [DimW-1:0]  rows_q, cols_q;
  logic             color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StepW'(65536);
      rows_q  <= DimW'(256);
      cols_q  <= DimW'(256);
      color_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STEP:       step_q  <= cfg_data_i[StepW-1:0];
        CFG_SRC_ROWS:   rows_q  <= cfg_data_i[DimW-1:0];
        CFG_SRC_COLS:   cols_q  <= cfg_data_i[DimW-1:0];
        CFG_COLOR_MODE: color_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // stage 1: coordinate products
  logic             v1_q, op1_q;
  logic [IdxW-1:0]  r1_q, c1_q;
  logic [WordW-1:0] pix1_q;
  logic [ProdW-1:0] pr1_q, pc1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      op1_q  <= in_data_i.operation;
      r1_q   <= in_data_i.pos_row;
      c1_q   <= in_data_i.pos_col;
      pix1_q <= {in_data_i.pix_ch2, in_data_i.pix_ch1, in_data_i.pix_ch0};
      pr1_q  <= ProdW'(step_q) * ProdW'({in_data_i.pos_row, 1'b1});
      pc1_q  <= ProdW'(step_q) * ProdW'({in_data_i.pos_col, 1'b1});
    end
  end

  // stage 2: pick neighbors and weights, form bank addresses
  axis_t ay, ax;
  logic [DimW-1:0] nrows, ncols;
  assign nrows = clamp_dim(rows_q, DimW'(MaxSrcRows));
  assign ncols = clamp_dim(cols_q, DimW'(MaxSrcCols));
  assign ay = pick_axis(pr1_q, nrows);
  assign ax = pick_axis(pc1_q, ncols);

  logic [BankRw-1:0] ra_even, ra_odd;
  logic [BankCw-1:0] ca_even, ca_odd;
  assign ra_even = ay.lo[RowW-1:1] + BankRw'(ay.lo[0]);
  assign ra_odd  = ay.lo[RowW-1:1];
  assign ca_even = ax.lo[ColW-1:1] + BankCw'(ax.lo[0]);
  assign ca_odd  = ax.lo[ColW-1:1];

  logic load_ok;
  assign load_ok = (r1_q < IdxW'(MaxSrcRows)) && (c1_q < IdxW'(MaxSrcCols));

  logic             v2_q, op2_q;
  logic [3:0]       we2_q;
  logic [BankAw-1:0] addr2_q [4];
  logic [WordW-1:0] pix2_q;
  logic             ty2_q, tx2_q;
  logic [WgtW-1:0]  wy1_2_q, wx1_2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q  <= 1'b0;
      we2_q <= '0;
    end else if (adv) begin
      v2_q  <= v1_q;
      we2_q <= '0;
      if (v1_q && op1_q == OpLoad && load_ok) begin
        we2_q[{r1_q[0], c1_q[0]}] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      op2_q   <= op1_q;
      pix2_q  <= pix1_q;
      ty2_q   <= ay.lo[0];
      tx2_q   <= ax.lo[0];
      wy1_2_q <= ay.w1;
      wx1_2_q <= ax.w1;
      for (int b = 0; b < 4; b++) begin
        if (op1_q == OpLoad) begin
          addr2_q[b] <= {r1_q[RowW-1:1], c1_q[ColW-1:1]};
        end else begin
          addr2_q[b] <= {(b[1] ? ra_odd : ra_even), (b[0] ? ca_odd : ca_even)};
        end
      end
    end
  end

  // stage 3: banked frame store, write and read in the same stage
  logic [WordW-1:0] rd3_q [4];
  logic             rd_en;
  assign rd_en = adv && v2_q && (op2_q == OpInterp);

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [WordW-1:0] bank_mem [BankDepth];
    always_ff @(posedge clk_i) begin
      if (adv && we2_q[g]) bank_mem[addr2_q[g]] <= pix2_q;
      if (rd_en) rd3_q[g] <= bank_mem[addr2_q[g]];
    end
  end

  logic            v3_q, ty3_q, tx3_q;
  logic [WgtW-1:0] wy1_3_q, wx1_3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q && (op2_q == OpInterp);
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ty3_q   <= ty2_q;
      tx3_q   <= tx2_q;
      wy1_3_q <= wy1_2_q;
      wx1_3_q <= wx1_2_q;
    end
  end

  // stage 4: vertical blend
  logic [WordW-1:0] p_tl, p_bl, p_tr, p_br;
  assign p_tl = rd3_q[{ty3_q,  tx3_q}];
  assign p_bl = rd3_q[{~ty3_q, tx3_q}];
  assign p_tr = rd3_q[{ty3_q,  ~tx3_q}];
  assign p_br = rd3_q[{~ty3_q, ~tx3_q}];

  logic            v4_q;
  logic [WordW-1:0] a4_q, b4_q;
  logic [WgtW-1:0] wx1_4_q;
  logic [WgtW-1:0] wy0_3;
  assign wy0_3 = WeightOne - wy1_3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv && v3_q) begin
      wx1_4_q <= wx1_3_q;
      for (int k = 0; k < 3; k++) begin
        a4_q[k*PixW +: PixW] <= mix(p_tl[k*PixW +: PixW], p_bl[k*PixW +: PixW],
                                    wy0_3, wy1_3_q);
        b4_q[k*PixW +: PixW] <= mix(p_tr[k*PixW +: PixW], p_br[k*PixW +: PixW],
                                    wy0_3, wy1_3_q);
      end
    end
  end

  // stage 5: horizontal blend into the output register
  logic [WgtW-1:0] wx0_4;
  assign wx0_4 = WeightOne - wx1_4_q;

  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv && v4_q) begin
      out_q.res_ch0 <= mix(a4_q[PixW-1:0], b4_q[PixW-1:0], wx0_4, wx1_4_q);
      out_q.res_ch1 <= color_q ? mix(a4_q[2*PixW-1:PixW], b4_q[2*PixW-1:PixW],
                                     wx0_4, wx1_4_q) : '0;
      out_q.res_ch2 <= color_q ? mix(a4_q[3*PixW-1:2*PixW], b4_q[3*PixW-1:2*PixW],
                                     wx0_4, wx1_4_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bir_pkg::*;

  class resample_scoreboard;
    logic [23:0] frame_mem [65536];
    int unsigned step_q16;
    int unsigned src_rows;
    int unsigned src_cols;
    bit          rgb;
    out_item_t   pixel_q[$];
    int unsigned errors;
    int unsigned checked;

    function void reset_state();
      step_q16 = 65536;
      src_rows = 256;
      src_cols = 256;
      rgb      = 1'b0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [21:0] value);
      case (idx)
        CFG_STEP:       step_q16 = 32'(value);
        CFG_SRC_ROWS:   src_rows = 32'(value[8:0]);
        CFG_SRC_COLS:   src_cols = 32'(value[8:0]);
        CFG_COLOR_MODE: rgb      = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned fit_dim(int unsigned v, int unsigned maxv);
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void axis(int unsigned idx, int unsigned n, output int unsigned lo,
                       output int unsigned w0, output int unsigned w1);
      longint unsigned prod;
      longint unsigned c;
      prod = longint'(step_q16) * (2 * longint'(idx) + 1);
      c = (prod > 65536) ? prod - 65536 : 0;
      if ((c >> 17) > 64'(n - 2)) begin
        lo = n - 2;
        w1 = 1024;
      end else begin
        lo = 32'(c >> 17);
        w1 = 32'(((c & 64'h1FFFF) + 64) >> 7);
      end
      w0 = 1024 - w1;
    endfunction

    function int unsigned sample(int unsigned r, int unsigned c, int ch);
      logic [23:0] w;
      w = frame_mem[16'(r * MaxSrcCols + c)];
      return 32'((w >> (8 * ch)) & 24'hFF);
    endfunction

    function logic [7:0] mix(int unsigned ylo, int unsigned yw0, int unsigned yw1,
                             int unsigned xlo, int unsigned xw0, int unsigned xw1,
                             int ch);
      int unsigned a;
      int unsigned b;
      a = (sample(ylo, xlo, ch) * yw0 + sample(ylo + 1, xlo, ch) * yw1) >> 10;
      b = (sample(ylo, xlo + 1, ch) * yw0 + sample(ylo + 1, xlo + 1, ch) * yw1) >> 10;
      return 8'((a * xw0 + b * xw1) >> 10);
    endfunction

    function void note_input(in_item_t it);
      int unsigned r, c, ylo, yw0, yw1, xlo, xw0, xw1;
      out_item_t px;
      r = 32'(it.pos_row);
      c = 32'(it.pos_col);
      if (it.operation == OpLoad) begin
        if (r < MaxSrcRows && c < MaxSrcCols)
          frame_mem[16'(r * MaxSrcCols + c)] = {it.pix_ch2, it.pix_ch1, it.pix_ch0};
        return;
      end
      axis(r, fit_dim(src_rows, MaxSrcRows), ylo, yw0, yw1);
      axis(c, fit_dim(src_cols, MaxSrcCols), xlo, xw0, xw1);
      px.res_ch0 = mix(ylo, yw0, yw1, xlo, xw0, xw1, 0);
      px.res_ch1 = rgb ? mix(ylo, yw0, yw1, xlo, xw0, xw1, 1) : 8'd0;
      px.res_ch2 = rgb ? mix(ylo, yw0, yw1, xlo, xw0, xw1, 2) : 8'd0;
      pixel_q.push_back(px);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_px;
      if (pixel_q.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      exp_px = pixel_q.pop_front();
      checked++;
      if (got.res_ch0 !== exp_px.res_ch0) begin
        $error("res_ch0 expected %0d actual %0d", exp_px.res_ch0, got.res_ch0);
        errors++;
      end
      if (got.res_ch1 !== exp_px.res_ch1) begin
        $error("res_ch1 expected %0d actual %0d", exp_px.res_ch1, got.res_ch1);
        errors++;
      end
      if (got.res_ch2 !== exp_px.res_ch2) begin
        $error("res_ch2 expected %0d actual %0d", exp_px.res_ch2, got.res_ch2);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [21:0] cfg_data;

  resample_scoreboard sb = new();
  bit          quiet;
  bit          long_hold;
  int unsigned hold_left;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned n_loads;
  int unsigned n_interp;
  int unsigned n_phases;

  bilinear_image_resampler_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // receiver: check each output transfer, then choose the next stall value
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (long_hold) begin
        long_hold = 1'b0;
        hold_left = 300;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
      end else begin
        out_stall  <= ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(0, 9);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= 20000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send(in_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_input(it);
    if (it.operation == OpLoad) n_loads++;
    else n_interp++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pixel_q.size() != 0) @(posedge clk);
    // loads give no result, so let the pipeline drain
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [21:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic load_pix(int unsigned r, int unsigned c, bit extreme);
    in_item_t it;
    it.operation = OpLoad;
    it.pos_row   = 10'(r);
    it.pos_col   = 10'(c);
    it.pix_ch0   = extreme ? {8{c[0]}} : 8'($urandom);
    it.pix_ch1   = extreme ? {8{r[0]}} : 8'($urandom);
    it.pix_ch2   = extreme ? {8{~c[0]}} : 8'($urandom);
    send(it);
  endtask

  task automatic interp(int unsigned r, int unsigned c);
    in_item_t it;
    it.operation = OpInterp;
    it.pos_row   = 10'(r);
    it.pos_col   = 10'(c);
    it.pix_ch0   = 8'($urandom);
    it.pix_ch1   = 8'($urandom);
    it.pix_ch2   = 8'($urandom);
    send(it);
  endtask

  // configure, fill the whole source area, then request output pixels
  task automatic run_phase(logic [21:0] step, logic [8:0] rows, logic [8:0] cols,
                           bit rgb_mode, int unsigned count, bit pressure);
    int unsigned nr, nc, lim_r, lim_c;
    wait_idle();
    write_reg(CFG_STEP, step);
    write_reg(CFG_SRC_ROWS, 22'(rows));
    write_reg(CFG_SRC_COLS, 22'(cols));
    write_reg(CFG_COLOR_MODE, 22'(rgb_mode));
    n_phases++;
    nr = sb.fit_dim(32'(rows), MaxSrcRows);
    nc = sb.fit_dim(32'(cols), MaxSrcCols);
    for (int unsigned r = 0; r < nr; r++)
      for (int unsigned c = 0; c < nc; c++) begin
        load_pix(r, c, 1'b0);
        if ($urandom_range(0, 40) == 0)
          load_pix($urandom_range(256, 1023), $urandom_range(0, 1023), 1'b0);
      end
    if (pressure) long_hold = 1'b1;
    lim_r = (step == 0) ? 1023 : 32'((longint'(nr) << 16) / step + 2);
    lim_c = (step == 0) ? 1023 : 32'((longint'(nc) << 16) / step + 2);
    if (lim_r > 1023) lim_r = 1023;
    if (lim_c > 1023) lim_c = 1023;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0)
        interp($urandom_range(0, 1023), $urandom_range(0, 1023));
      else
        interp($urandom_range(0, lim_r), $urandom_range(0, lim_c));
    end
  endtask

  initial begin
    logic [21:0] st;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_STEP;
    cfg_data   = '0;
    quiet      = 1'b0;
    long_hold  = 1'b0;
    hold_left  = 0;
    burst_left = 0;
    idle_cycles = 0;
    n_loads = 0;
    n_interp = 0;
    n_phases = 0;
    sb.reset_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 2x2 source with extreme pixels, corners and clamped indices
    write_reg(CFG_SRC_ROWS, 22'd2);
    write_reg(CFG_SRC_COLS, 22'd2);
    write_reg(CFG_COLOR_MODE, 22'd1);
    n_phases++;
    for (int unsigned r = 0; r < 2; r++)
      for (int unsigned c = 0; c < 2; c++) load_pix(r, c, 1'b1);
    load_pix(256, 0, 1'b0);
    load_pix(0, 1023, 1'b0);
    load_pix(1023, 1023, 1'b1);
    interp(0, 0);
    interp(0, 1);
    interp(1, 0);
    interp(1, 1);
    interp(1023, 1023);
    interp(512, 0);
    run_phase(22'd32768, 9'd0, 9'd1, 1'b0, 6, 1'b0);
    run_phase(22'd0, 9'd3, 9'd3, 1'b1, 4, 1'b0);
    run_phase(22'h3FFFFF, 9'd511, 9'd2, 1'b1, 10, 1'b0);
    run_phase(22'd1, 9'd2, 9'd5, 1'b0, 10, 1'b0);

    for (int k = 0; k < 10; k++) begin
      case ($urandom_range(0, 3))
        0: st = 22'd65536;
        1: st = 22'($urandom_range(1, 65535));
        2: st = 22'($urandom_range(65536, 262144));
        default: st = 22'($urandom);
      endcase
      run_phase(st, 9'($urandom_range(2, 5)), 9'($urandom_range(2, 5)),
                1'($urandom_range(0, 1)), 12, k == 3);
    end
    quiet = 1'b1;
    run_phase(22'd45000, 9'd5, 9'd5, 1'b1, 30, 1'b0);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Covered %0d loads and %0d interpolations over %0d register settings,",
             n_loads, n_interp, n_phases);
    $display("%0d output pixels compared, %0d left unmatched.", sb.checked,
             sb.pixel_q.size());
    if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bir_pkg.sv
rtl/bilinear_image_resampler_top.sv
verif/tb_top.sv
